// ===== hw/rtl/binary_median_speck_filter_unit_macros.svh =====
// Assertion helpers for the speck filter.
`ifndef BINARY_MEDIAN_SPECK_FILTER_UNIT_MACROS_SVH
`define BINARY_MEDIAN_SPECK_FILTER_UNIT_MACROS_SVH

// Implication checked on every clock, off during reset.
`define BMSF_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication checked on every clock, off during reset.
`define BMSF_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/bmsf_pkg.sv =====
package bmsf_pkg;

   localparam int unsigned NG_RESET     = 75;
   localparam int unsigned MEDIAN_MIN   = 5;
   localparam logic [7:0]  FLAG_SET     = 8'd1;
   localparam int unsigned OP_STREAM_W  = 9;
   localparam int unsigned OP_GATE_W    = 10;
   localparam int unsigned NG_W         = 11;

   typedef enum logic {
      CMD_DATA  = 1'b0,
      CMD_FLUSH = 1'b1
   } command_type;

   typedef struct packed {
      logic       command;
      logic [4:0] beam;
      logic [1:0] channel;
      logic [7:0] quality_flag;
   } req_type;

   typedef struct packed {
      logic [4:0] out_beam;
      logic [1:0] out_channel;
      logic [7:0] out_gate;
      logic       filtered_flag;
      logic       removed;
      logic       last_of_record;
   } rsp_type;

   // classified gate handed from front to back
   typedef struct packed {
      logic                   flush;
      logic                   raw_set;
      logic                   last;
      logic [OP_STREAM_W-1:0] stream;
      logic [4:0]             beam;
      logic [1:0]             channel;
      logic [OP_GATE_W-1:0]   gate;
   } op_type;

   typedef struct packed {
      logic [4:0] out_level;
   } back_status_type;

   function automatic logic [1:0] ones3(input logic [2:0] c);
      ones3 = {1'b0, c[0]} + {1'b0, c[1]} + {1'b0, c[2]};
   endfunction

   function automatic rsp_type make_rsp(input logic [4:0] beam, input logic [1:0] channel,
                                        input logic [7:0] gate, input logic [2:0] left,
                                        input logic [2:0] mid, input logic [2:0] right,
                                        input logic last);
      logic [3:0] sum;
      logic       keep;
      sum  = {2'b00, ones3(left)} + {2'b00, ones3(mid)} + {2'b00, ones3(right)};
      keep = (sum >= 4'(MEDIAN_MIN));
      make_rsp.out_beam       = beam;
      make_rsp.out_channel    = channel;
      make_rsp.out_gate       = gate;
      make_rsp.filtered_flag  = mid[1] & keep;
      make_rsp.removed        = mid[1] & ~keep;
      make_rsp.last_of_record = last;
   endfunction

endpackage

// ===== hw/rtl/bmsf_front.sv =====
module bmsf_front
   import bmsf_pkg::*;
#(
   parameter int unsigned MAX_BEAMS    = 32,
   parameter int unsigned MAX_CHANNELS = 4,
   parameter int unsigned MAX_GATES    = 256
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    csr_valid,
   input  logic [8:0] csr_wdata,
   input  logic    accept,
   input  req_type req_data,
   output op_type  op
);
   localparam int unsigned GATE_W = $clog2(MAX_GATES);

   logic [8:0]         num_gates_ff;
   logic [GATE_W-1:0]  gate_ff, gate_in;
   logic [OP_STREAM_W-1:0] stream_ff, stream_in;
   logic [4:0]         beam_ff, beam_in;
   logic [1:0]         chan_ff, chan_in;
   logic [4:0]         beam_mod [32];
   logic [1:0]         chan_mod [4];
   logic [NG_W-1:0]    ng_raw, ng;
   logic [GATE_W-1:0]  g;
   logic               last;

   for (genvar i = 0; i < 32; i++) begin : g_bm
      assign beam_mod[i] = 5'(i % MAX_BEAMS);
   end
   for (genvar i = 0; i < 4; i++) begin : g_cm
      assign chan_mod[i] = 2'(i % MAX_CHANNELS);
   end

   always_comb begin
      ng_raw = (num_gates_ff == 9'd0) ? NG_W'(1) : NG_W'(num_gates_ff);
      ng     = (ng_raw > NG_W'(MAX_GATES)) ? NG_W'(MAX_GATES) : ng_raw;
      g      = (NG_W'(gate_ff) >= ng) ? GATE_W'(ng - NG_W'(1)) : gate_ff;
      last   = (NG_W'(g) == ng - NG_W'(1));
      gate_in = last ? '0 : GATE_W'(g + GATE_W'(1));
      if (g == '0) begin
         beam_in   = beam_mod[req_data.beam];
         chan_in   = chan_mod[req_data.channel];
         stream_in = OP_STREAM_W'(OP_STREAM_W'(beam_in) * OP_STREAM_W'(MAX_CHANNELS))
                     + OP_STREAM_W'(chan_in);
      end else begin
         beam_in   = beam_ff;
         chan_in   = chan_ff;
         stream_in = stream_ff;
      end
      op.flush   = (req_data.command == CMD_FLUSH);
      op.raw_set = (req_data.quality_flag == FLAG_SET);
      op.last    = last;
      op.stream  = stream_in;
      op.beam    = beam_in;
      op.channel = chan_in;
      op.gate    = OP_GATE_W'(g);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_gates_ff <= 9'(NG_RESET);
         gate_ff      <= '0;
         stream_ff    <= '0;
         beam_ff      <= '0;
         chan_ff      <= '0;
      end else begin
         if (csr_valid) num_gates_ff <= csr_wdata;
         if (accept) begin
            gate_ff   <= gate_in;
            stream_ff <= stream_in;
            beam_ff   <= beam_in;
            chan_ff   <= chan_in;
         end
      end
   end
endmodule

// ===== hw/rtl/bmsf_queue.sv =====
module bmsf_queue
   import bmsf_pkg::*;
#(
   parameter int unsigned DEPTH = 4
) (
   input  logic   clock,
   input  logic   reset,
   input  logic   push,
   input  op_type push_data,
   input  logic   pop,
   output logic   not_empty,
   output logic   not_full,
   output op_type head,
   output logic [$clog2(DEPTH+1)-1:0] level
);
   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned LW = $clog2(DEPTH+1);

   op_type        mem [DEPTH];
   logic [PW-1:0] wp_ff, rp_ff;
   logic [LW-1:0] level_ff;

   assign not_empty = (level_ff != '0);
   assign not_full  = (level_ff != LW'(DEPTH));
   assign head      = mem[rp_ff];
   assign level     = level_ff;

   always_ff @(posedge clock) begin
      if (push) mem[wp_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         rp_ff    <= '0;
         level_ff <= '0;
      end else begin
         if (push) wp_ff <= (wp_ff == PW'(DEPTH-1)) ? '0 : PW'(wp_ff + PW'(1));
         if (pop)  rp_ff <= (rp_ff == PW'(DEPTH-1)) ? '0 : PW'(rp_ff + PW'(1));
         level_ff <= LW'(level_ff + LW'(push) - LW'(pop));
      end
   end
endmodule

// ===== hw/rtl/bmsf_back.sv =====
module bmsf_back
   import bmsf_pkg::*;
#(
   parameter int unsigned MAX_BEAMS    = 32,
   parameter int unsigned MAX_CHANNELS = 4,
   parameter int unsigned MAX_GATES    = 256
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            op_valid,
   input  op_type          op,
   output logic            op_ready,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_type         rsp_data,
   output back_status_type status
);
   localparam int unsigned NSTREAMS = MAX_BEAMS * MAX_CHANNELS;
   localparam int unsigned SW       = (NSTREAMS > 1) ? $clog2(NSTREAMS) : 1;
   localparam int unsigned GATE_W   = $clog2(MAX_GATES);
   localparam int unsigned NADDR    = NSTREAMS * MAX_GATES;
   localparam int unsigned AW       = $clog2(NADDR);
   localparam int unsigned ODEPTH   = 8;
   localparam int unsigned OPW      = $clog2(ODEPTH);
   localparam int unsigned OLW      = $clog2(ODEPTH+1);

   logic [1:0]    row_mem [NADDR];
   logic [1:0]    cnt_mem [NSTREAMS];
   logic [NSTREAMS-1:0] cnt_valid_ff;

   logic          pop;
   logic [AW-1:0] pop_addr;
   logic [SW-1:0] pop_stream;

   logic          s2_valid_ff;
   op_type        s2_op_ff;
   logic [AW-1:0] s2_addr_ff;
   logic [SW-1:0] s2_stream;
   logic [1:0]    row_rd_ff, row_fwd_ff, cnt_rd_ff, cnt_fwd_ff;
   logic          row_hit_ff, cnt_hit_ff;
   logic [2:0]    cw0_ff, cw1_ff;

   logic [1:0]    e, cnt, row_wdata, cnt_wdata;
   logic          open, cur, first, row_we, cnt_we;
   logic [GATE_W-1:0] g;
   logic [2:0]    col;
   rsp_type       r0, r1, slot0;
   logic          push0, push1;
   logic [1:0]    push_n;

   rsp_type        omem [ODEPTH];
   logic [OPW-1:0] owp_ff, orp_ff;
   logic [OLW-1:0] olevel_ff;
   logic           opop;

   assign pop_stream = SW'(op.stream);
   assign pop_addr   = AW'(AW'(pop_stream) * AW'(MAX_GATES)) + AW'(op.gate[GATE_W-1:0]);
   assign s2_stream  = SW'(s2_op_ff.stream);

   always_comb begin
      e     = row_hit_ff ? row_fwd_ff : row_rd_ff;
      cnt   = cnt_hit_ff ? cnt_fwd_ff : cnt_rd_ff;
      open  = (cnt != 2'd0);
      g     = s2_op_ff.gate[GATE_W-1:0];
      first = (g == '0);
      cur   = s2_op_ff.flush ? e[0] : s2_op_ff.raw_set;
      col   = {e[1], e[0], cur};
      row_we    = s2_valid_ff && (open || !s2_op_ff.flush);
      row_wdata = open ? {e[0], cur} : {cur, cur};
      cnt_we    = s2_valid_ff && s2_op_ff.last;
      if (s2_op_ff.flush)   cnt_wdata = 2'd0;
      else if (cnt == 2'd2) cnt_wdata = 2'd2;
      else                  cnt_wdata = cnt + 2'd1;
      r0 = make_rsp(s2_op_ff.beam, s2_op_ff.channel, 8'(g - GATE_W'(1)),
                    cw0_ff, cw1_ff, col, 1'b0);
      r1 = make_rsp(s2_op_ff.beam, s2_op_ff.channel, 8'(g),
                    first ? col : cw1_ff, col, col, 1'b1);
      push0  = s2_valid_ff && open && !first;
      push1  = s2_valid_ff && open && s2_op_ff.last;
      push_n = {1'b0, push0} + {1'b0, push1};
      slot0  = push0 ? r0 : r1;
      opop   = rsp_valid && rsp_ready;
      op_ready = ((OLW+1)'(olevel_ff) + (OLW+1)'(push_n) + (OLW+1)'(2))
                 <= (OLW+1)'(ODEPTH);
      pop    = op_valid && op_ready;
   end

   // row and count stores: read at pop, written in the cycle after
   always_ff @(posedge clock) begin
      if (pop) begin
         row_rd_ff <= row_mem[pop_addr];
         cnt_rd_ff <= cnt_mem[pop_stream];
      end
      if (row_we) row_mem[s2_addr_ff] <= row_wdata;
      if (cnt_we) cnt_mem[s2_stream] <= cnt_wdata;
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s2_op_ff   <= op;
         s2_addr_ff <= pop_addr;
         row_hit_ff <= row_we && (s2_addr_ff == pop_addr);
         row_fwd_ff <= row_wdata;
         cnt_hit_ff <= (cnt_we && (s2_stream == pop_stream)) || !cnt_valid_ff[pop_stream];
         cnt_fwd_ff <= (cnt_we && (s2_stream == pop_stream)) ? cnt_wdata : 2'd0;
      end
      if (push0 || push1) omem[owp_ff] <= slot0;
      if (push0 && push1) omem[OPW'(owp_ff + OPW'(1))] <= r1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         cnt_valid_ff <= '0;
         cw0_ff       <= '0;
         cw1_ff       <= '0;
         owp_ff       <= '0;
         orp_ff       <= '0;
         olevel_ff    <= '0;
      end else begin
         s2_valid_ff <= pop;
         if (cnt_we) cnt_valid_ff[s2_stream] <= 1'b1;
         if (s2_valid_ff) begin
            if (first) begin
               cw0_ff <= col;
               cw1_ff <= col;
            end else begin
               cw0_ff <= cw1_ff;
               cw1_ff <= col;
            end
         end
         owp_ff    <= OPW'(owp_ff + OPW'(push_n));
         if (opop) orp_ff <= OPW'(orp_ff + OPW'(1));
         olevel_ff <= OLW'(olevel_ff + OLW'(push_n) - OLW'(opop));
      end
   end

   assign rsp_valid        = (olevel_ff != '0);
   assign rsp_data         = omem[orp_ff];
   assign status.out_level = 5'(olevel_ff);
endmodule

// ===== hw/rtl/binary_median_speck_filter_unit.sv =====
// Binary 3x3 median speck filter over interleaved beam/channel range-time grids. One gate
// is accepted per cycle while the queue has room; results come out one per cycle while
// rsp_ready is high, a record behind, two on the last gate of a record, drained by an
// eight-beat result buffer. The row store (two flag bits per stream and gate) is read
// when a gate leaves the four-entry queue and written the next cycle, with a bypass for
// back-to-back hits on the same entry; it has no clearing pass and the per-stream row
// counts use reset-cleared valid bits, so the block takes gates straight after reset.
module binary_median_speck_filter_unit
   import bmsf_pkg::*;
#(
   parameter int unsigned MAX_BEAMS    = 32,
   parameter int unsigned MAX_CHANNELS = 4,
   parameter int unsigned MAX_GATES    = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [8:0] csr_wdata
);
`include "binary_median_speck_filter_unit_macros.svh"

   localparam int unsigned QDEPTH = 4;

   op_type          front_op, q_head;
   logic            accept, q_not_empty, q_not_full, op_ready;
   logic [$clog2(QDEPTH+1)-1:0] q_level;
   back_status_type back_status;

   assign csr_ready = 1'b1;
   assign req_ready = q_not_full;
   assign accept    = req_valid && req_ready;

   bmsf_front #(
      .MAX_BEAMS(MAX_BEAMS), .MAX_CHANNELS(MAX_CHANNELS), .MAX_GATES(MAX_GATES)
   ) u_front (
      .clock(clock), .reset(reset), .csr_valid(csr_valid), .csr_wdata(csr_wdata),
      .accept(accept), .req_data(req_data), .op(front_op)
   );

   bmsf_queue #(.DEPTH(QDEPTH)) u_queue (
      .clock(clock), .reset(reset), .push(accept), .push_data(front_op),
      .pop(q_not_empty && op_ready), .not_empty(q_not_empty), .not_full(q_not_full),
      .head(q_head), .level(q_level)
   );

   bmsf_back #(
      .MAX_BEAMS(MAX_BEAMS), .MAX_CHANNELS(MAX_CHANNELS), .MAX_GATES(MAX_GATES)
   ) u_back (
      .clock(clock), .reset(reset), .op_valid(q_not_empty), .op(q_head),
      .op_ready(op_ready), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_data(rsp_data), .status(back_status)
   );

   `BMSF_ASSERT_IMP(a_out_level, 1'b1, back_status.out_level <= 5'd8, "result buffer overrun")
   `BMSF_ASSERT_IMP(a_rsp_level, rsp_valid, back_status.out_level != 5'd0, "beat from empty buffer")
   `BMSF_ASSERT_NXT(a_q_hold, req_valid && req_ready, q_level != '0, "accepted gate lost")
endmodule
